>>> hw/rtl/tpu_pkg.sv
// Shared types, constants and helper functions of the timestamp permutation unrank unit.
package tpu_pkg;

    localparam int SLOT_COUNT       = 10;
    localparam int IDX_W            = 4;
    localparam int ORDER_LENGTH_DEF = 10;
    localparam int TS_W             = 32;
    localparam int ADDR_W           = 3;

    // rank range and constant-divisor reduction
    localparam int RANK_W       = 16;
    localparam int RANK_MODULUS = 40320;
    localparam int QUOT_W       = 16;
    localparam int REM_W        = 17;
    localparam int RANK_SHIFT   = 46;
    localparam logic [30:0] RANK_RECIP = 31'((64'd1 << RANK_SHIFT) / RANK_MODULUS);

    localparam logic [TS_W-1:0] BASE_RESET = 32'd1492973331;

    // register index, taken from paddr[2]
    localparam logic REG_BASE_TS = 1'b0;

    typedef logic [SLOT_COUNT-1:0][IDX_W-1:0] t_slots;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        t_slots            pool;
        t_slots            slots;
    } t_unrank;

    function automatic int unsigned fact(input int unsigned k);
        int unsigned f;
        f = 1;
        for (int unsigned i = 2; i <= k; i++) begin
            f = f * i;
        end
        return f;
    endfunction

    function automatic t_slots identity_slots();
        t_slots s;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            s[i] = IDX_W'(i);
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/tpu_digit_stage.sv
// One pipeline stage that extracts a factorial-base digit and takes that element from the pool.
module tpu_digit_stage #(
    parameter int ORDER_LENGTH = tpu_pkg::ORDER_LENGTH_DEF,
    parameter int DIGIT        = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_vld,
    input  tpu_pkg::t_unrank i_item,
    output logic             o_vld,
    output tpu_pkg::t_unrank o_item
);
    import tpu_pkg::*;

    localparam int          LEFT = ORDER_LENGTH - DIGIT;
    localparam int unsigned FACT = fact(LEFT - 1);

    logic [IDX_W-1:0]  n_digit;
    logic [RANK_W-1:0] n_sub;
    t_unrank           n_item;
    logic              r_vld;
    t_unrank           r_item;

    always_comb begin
        n_digit = '0;
        n_sub   = '0;
        // thresholds are monotonic: the last one passed is the digit
        for (int k = 1; k < SLOT_COUNT; k++) begin
            if ((k < LEFT) && (32'(i_item.rank) >= 32'(k * FACT))) begin
                n_digit = IDX_W'(k);
                n_sub   = RANK_W'(k * FACT);
            end
        end
        n_item              = i_item;
        n_item.rank         = i_item.rank - n_sub;
        n_item.slots[DIGIT] = i_item.pool[n_digit];
        // close the gap left by the taken element
        for (int j = 0; j < SLOT_COUNT - 1; j++) begin
            if (j >= int'(n_digit)) begin
                n_item.pool[j] = i_item.pool[j + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

>>> hw/rtl/timestamp_permutation_unrank_unit.sv
// Top level: timestamp to hash-stage order, pipelined unranking with stream and APB ports.
//
//  channel   | signals                         | payload
//  ----------+---------------------------------+-------------------------------------
//  stream in | s_tvalid s_tready s_tdata[31:0] | block_time
//  stream out| m_tvalid m_tready m_tdata[39:0] | slot_0 .. slot_9, 4 bits each
//  config    | psel penable pwrite paddr ...   | base_timestamp at byte address 0
//
//  One transfer per cycle in and out while m_tready is high; the pipeline is the
//  four front stages (subtract, reciprocal multiply, remainder, correction) and one
//  digit stage per slot of the order.
//  Reset (synchronous, active low) empties every stage and loads base_timestamp with
//  its default. Each stage loads when it is empty or its successor moves, so a stall
//  at m_tready fills bubbles first and loses or repeats nothing.
module timestamp_permutation_unrank_unit #(
    parameter int ORDER_LENGTH = tpu_pkg::ORDER_LENGTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // stream in
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [tpu_pkg::TS_W-1:0]   s_tdata,   // [31:0] block_time
    // stream out
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [39:0]                m_tdata,   // [3:0] slot_0, [7:4] slot_1 .. [39:36] slot_9
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import tpu_pkg::*;

    localparam int FRONT  = 4;
    localparam int NSTAGE = FRONT + ORDER_LENGTH;

    logic [TS_W-1:0]   r_base;

    // front stages
    logic [FRONT-1:0]  r_vld;
    logic [TS_W-1:0]   r_diff;
    logic              r_neg1;
    logic [REM_W-1:0]  r_low1;
    logic [QUOT_W-1:0] r_quot;
    logic              r_neg2;
    logic [REM_W-1:0]  r_rem;
    t_unrank           r_item3;

    logic [61:0]       w_prod;
    logic [31:0]       w_qm;
    logic [RANK_W-1:0] w_rank;

    // digit stages
    logic    [ORDER_LENGTH-1:0] w_dvld;
    t_unrank                    w_ditem [ORDER_LENGTH];

    logic [NSTAGE-1:0] w_vld;
    logic [NSTAGE-1:0] w_en;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_BASE_TS)) begin
            r_base <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_BASE_TS) ? r_base : '0;

    // ---------------- load enables ----------------
    // a stage loads when empty or when the stage after it moves on
    assign w_vld = {w_dvld, r_vld};

    always_comb begin
        w_en[NSTAGE-1] = !w_vld[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_en[k] = !w_vld[k] || w_en[k + 1];
        end
    end

    assign s_tready = w_en[0];

    // ---------------- front stages ----------------
    // the quotient estimate is low by at most one; the remainder stays below twice
    // the modulus, and one compare and subtract corrects it
    assign w_prod = {31'b0, r_diff[30:0]} * {31'b0, RANK_RECIP};
    assign w_qm   = 32'(r_quot) * 32'(RANK_MODULUS);

    always_comb begin
        if (r_neg2) begin
            // negative difference: identity order
            w_rank = '0;
        end else if (r_rem >= REM_W'(RANK_MODULUS)) begin
            w_rank = RANK_W'(r_rem - REM_W'(RANK_MODULUS));
        end else begin
            w_rank = RANK_W'(r_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= s_tvalid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_diff <= s_tdata - r_base;
        end
        if (w_en[1]) begin
            r_neg1 <= r_diff[TS_W-1];
            r_low1 <= r_diff[REM_W-1:0];
            r_quot <= w_prod[RANK_SHIFT +: QUOT_W];
        end
        if (w_en[2]) begin
            r_neg2 <= r_neg1;
            r_rem  <= r_low1 - w_qm[REM_W-1:0];
        end
        if (w_en[3]) begin
            r_item3.rank  <= w_rank;
            r_item3.pool  <= identity_slots();
            r_item3.slots <= identity_slots();
        end
    end

    // ---------------- digit stages ----------------
    for (genvar g = 0; g < ORDER_LENGTH; g++) begin : g_digit
        tpu_digit_stage #(
            .ORDER_LENGTH (ORDER_LENGTH),
            .DIGIT        (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_en[FRONT + g]),
            .i_vld   ((g == 0) ? r_vld[FRONT-1] : w_dvld[(g == 0) ? 0 : g - 1]),
            .i_item  ((g == 0) ? r_item3 : w_ditem[(g == 0) ? 0 : g - 1]),
            .o_vld   (w_dvld[g]),
            .o_item  (w_ditem[g])
        );
    end

    assign m_tvalid = w_dvld[ORDER_LENGTH-1];
    assign m_tdata  = 40'(w_ditem[ORDER_LENGTH-1].slots);

    // ---------------- assertions ----------------
    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled while the output holds no transfer");

    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_rem < REM_W'(2 * RANK_MODULUS)))
        else $error("remainder estimate out of range");

    a_rank_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r_item3.rank < RANK_W'(RANK_MODULUS)))
        else $error("rank not reduced below modulus");

    a_fixed_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((ORDER_LENGTH != SLOT_COUNT) ||
                      ((m_tdata[3:0] == IDX_W'(0)) && (m_tdata[7:4] == IDX_W'(1)))))
        else $error("leading slots not 0 and 1");

endmodule

>>> tb/tb_timestamp_permutation_unrank_unit.sv
// Self-checking testbench for the timestamp permutation unrank unit: random stream traffic, APB setup.
module tb_timestamp_permutation_unrank_unit;

    localparam int ORDER_LEN    = tpu_pkg::ORDER_LENGTH_DEF;
    localparam int SLOTS        = tpu_pkg::SLOT_COUNT;
    localparam int RESET_CYCLES = 6;
    localparam int ITEMS_PHASE  = 125;
    localparam int PHASES       = 7;
    // pipeline depth is ORDER_LENGTH + 4; drain a generous multiple of it
    localparam int DRAIN_CYCLES = 2 * (ORDER_LEN + 4) + 8;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 150;
    localparam int REPORT_MAX   = 10;

    localparam logic [tpu_pkg::ADDR_W-1:0] ADDR_BASE_TS = {tpu_pkg::REG_BASE_TS, 2'b00};
    localparam logic [tpu_pkg::ADDR_W-1:0] ADDR_UNUSED  = {1'b1, 2'b00};
    localparam logic                       APB_WRITE    = 1'b1;
    localparam logic                       APB_READ     = 1'b0;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] block_time
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [3:0] slot_0, [7:4] slot_1 .. [39:36] slot_9
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [tpu_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    timestamp_permutation_unrank_unit #(
        .ORDER_LENGTH(ORDER_LEN)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // timestamps waiting to be offered, and stage orders waiting to come out
    logic [31:0]     ts_backlog[$];
    tpu_pkg::t_slots pending_orders[$];
    logic [31:0]     base_model = tpu_pkg::BASE_RESET;
    int              error_count = 0;

    // Unrank the lexicographic permutation picked by the timestamp offset from base.
    function automatic tpu_pkg::t_slots unrank_order(input logic [31:0] ts,
                                                     input logic [31:0] base);
        logic [31:0]     diff;
        int unsigned     rank;
        int unsigned     digit;
        int unsigned     left;
        int unsigned     f;
        logic [3:0]      pool [SLOTS];
        tpu_pkg::t_slots order;
        diff = ts - base;
        // a negative offset keeps the identity order
        rank = diff[31] ? 0 : diff % tpu_pkg::RANK_MODULUS;
        for (int i = 0; i < SLOTS; i++) begin
            pool[i]  = 4'(i);
            order[i] = 4'(i);
        end
        left = ORDER_LEN;
        for (int i = 0; i < ORDER_LEN; i++) begin
            f = 1;
            for (int k = 2; k <= ORDER_LEN - 1 - i; k++) begin
                f = f * k;
            end
            digit = rank / f;
            rank  = rank % f;
            // saturate a digit past the remaining choices to the last element
            if (digit >= left) begin
                digit = left - 1;
            end
            order[i] = pool[digit];
            for (int unsigned j = digit; j + 1 < left; j++) begin
                pool[j] = pool[j + 1];
            end
            left--;
        end
        return order;
    endfunction

    // Draw a timestamp: half are offsets that land on every rank, plus wide offsets, sign-edge and noise.
    function automatic logic [31:0] pick_timestamp(input logic [31:0] base);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return base + $urandom_range(0, tpu_pkg::RANK_MODULUS - 1);
            5:             return base + $urandom_range(0, 32'h7FFF_FFFF);
            6:             return base + 32'h7FFF_FFFE + $urandom_range(0, 3);
            7:             return base - $urandom_range(1, 1000);
            default:       return $urandom;
        endcase
    endfunction

    // One APB transfer: setup cycle, then access until pready.
    task automatic reg_access(input logic wr, input logic [tpu_pkg::ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        rdata = prdata;
        if (wr && addr == ADDR_BASE_TS) begin
            base_model = wdata;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ---------------------------------------------------------------------------------
    // Sender: offer backlog items in bursts separated by random gaps. Hold tvalid and
    // tdata steady until the transfer completes.
    // ---------------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_orders.push_back(unrank_order(s_tdata, base_model));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (ts_backlog.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= ts_backlog.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Receiver: check each result transfer against the oldest predicted order, and
    // drive tready from a rotating stall pattern. Twice, drop tready for a long hold
    // so the pipeline backs up into the input.
    // ---------------------------------------------------------------------------------
    int              results_seen = 0;
    int              hold_left    = 0;
    logic [7:0]      stall_phase  = '0;
    logic            slot_bad;
    tpu_pkg::t_slots got_order;
    tpu_pkg::t_slots want_order;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got_order = m_tdata;
                if (pending_orders.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display("unexpected result %h with no order pending", m_tdata);
                    end
                end else begin
                    want_order = pending_orders.pop_front();
                    slot_bad   = 1'b0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (got_order[i] !== want_order[i]) begin
                            slot_bad = 1'b1;
                        end
                    end
                    if (slot_bad) begin
                        error_count++;
                        if (error_count <= REPORT_MAX) begin
                            $display("order mismatch (slot_9..slot_0): expected %h, got %h",
                                     want_order, got_order);
                        end
                    end
                end
                if (results_seen == 200 || results_seen == 600) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            stall_phase <= stall_phase + 8'd1;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (stall_phase[7:6])
                    2'd0:    m_tready <= 1'b1;
                    2'd1:    m_tready <= 1'($urandom_range(0, 1));
                    2'd2:    m_tready <= (stall_phase[1:0] == 2'd0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if no transfer of any kind happens for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Sequencer: per phase after the first set base_timestamp while idle; per phase read it back, queue items,
    // then wait for every transfer and result to complete.
    // ---------------------------------------------------------------------------------
    logic [31:0] phase_base [PHASES];
    logic [31:0] readback;

    initial begin
        phase_base[0] = tpu_pkg::BASE_RESET;
        phase_base[1] = 32'h0000_0000;
        phase_base[2] = 32'hFFFF_FFFF;
        phase_base[3] = 32'h8000_0000;
        phase_base[4] = 32'h7FFF_FFFF;
        phase_base[5] = $urandom;
        phase_base[6] = $urandom;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            // phase 0 runs on the reset value of the register
            if (p > 0) begin
                reg_access(APB_WRITE, ADDR_BASE_TS, phase_base[p], readback);
            end
            // a write to an address with no register must leave base_timestamp alone
            if (p == 3) begin
                reg_access(APB_WRITE, ADDR_UNUSED, ~phase_base[p], readback);
            end
            reg_access(APB_READ, ADDR_BASE_TS, '0, readback);
            if (readback !== base_model) begin
                error_count++;
                if (error_count <= REPORT_MAX) begin
                    $display("base_timestamp readback: expected %h, got %h",
                             base_model, readback);
                end
            end

            if (p == 0) begin
                // rank zero, small and largest rank, wrap of the modulus, sign boundary
                ts_backlog.push_back(base_model);
                ts_backlog.push_back(base_model + 32'd1);
                ts_backlog.push_back(base_model + 32'd5039);
                ts_backlog.push_back(base_model + 32'd40319);
                ts_backlog.push_back(base_model + 32'd40320);
                ts_backlog.push_back(base_model - 32'd1);
                ts_backlog.push_back(base_model + 32'h7FFF_FFFF);
                ts_backlog.push_back(base_model + 32'h8000_0000);
                ts_backlog.push_back(32'h0000_0000);
                ts_backlog.push_back(32'hFFFF_FFFF);
                ts_backlog.push_back(32'hAAAA_AAAA);
                ts_backlog.push_back(32'h5555_5555);
            end
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                ts_backlog.push_back(pick_timestamp(base_model));
            end

            do begin
                @(posedge i_clk);
            end while (ts_backlog.size() != 0 || s_tvalid || pending_orders.size() != 0);
        end

        // let any stray result surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_orders.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
